// ===== sv/urlsplit_pkg.sv =====
// Package for the URL component splitter: item and result types,
// status codes and the default text length limit. No dependencies.
package urlsplit_pkg;

  localparam int unsigned URLSPLIT_MAX_LEN_DEFAULT = 512;
  localparam int unsigned FIELD_W = 10;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_NO_SEP    = 3'd2;
  localparam logic [2:0] ST_NO_HOST   = 3'd3;
  localparam logic [2:0] ST_PORT_OVFL = 3'd4;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               scheme_id;
    logic [FIELD_W-1:0] scheme_length;
    logic [FIELD_W-1:0] host_start;
    logic [FIELD_W-1:0] host_length;
    logic [15:0]        port_number;
    logic [FIELD_W-1:0] path_start;
    logic [FIELD_W-1:0] path_length;
  } result_t;

endpackage

// ===== sv/urlsplit_if.sv =====
// Handshake channel interfaces for the URL component splitter: the
// character input channel and the result channel. No dependencies.
interface urlsplit_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last_byte;

  modport source (output valid, output char_byte, output last_byte, input ready);
  modport sink (input valid, input char_byte, input last_byte, output ready);
endinterface

interface urlsplit_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        scheme_id;
  logic [9:0]  scheme_length;
  logic [9:0]  host_start;
  logic [9:0]  host_length;
  logic [15:0] port_number;
  logic [9:0]  path_start;
  logic [9:0]  path_length;

  modport source (output valid, output status, output scheme_id, output scheme_length,
                  output host_start, output host_length, output port_number,
                  output path_start, output path_length, input ready);
  modport sink (input valid, input status, input scheme_id, input scheme_length,
                input host_start, input host_length, input port_number,
                input path_start, input path_length, output ready);
endinterface

// ===== sv/urlsplit_in_stage.sv =====
// Input register of the URL component splitter. Holds one accepted item
// until the parser consumes it. Depends on urlsplit_pkg and urlsplit_in_if.
module urlsplit_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  urlsplit_in_if.sink          chars,
  output logic                 item_valid,
  output urlsplit_pkg::item_t  item,
  input  logic                 item_take
);
  import urlsplit_pkg::*;

  // The register refills in the same cycle that its item is consumed.
  assign chars.ready = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (chars.ready) begin
      item_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      item.char_byte <= chars.char_byte;
      item.last_byte <= chars.last_byte;
    end
  end

endmodule

// ===== sv/urlsplit_parser.sv =====
// Running parse state and result register of the URL component splitter.
// Depends on urlsplit_pkg and urlsplit_out_if.
module urlsplit_parser #(
  parameter int unsigned MAX_URL_LEN = urlsplit_pkg::URLSPLIT_MAX_LEN_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  urlsplit_pkg::item_t  item,
  output logic                 item_take,
  urlsplit_out_if.source       results
);
  import urlsplit_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_URL_LEN + 1);
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_URL_LEN);

  localparam logic [1:0] PH_SEARCH = 2'd0;
  localparam logic [1:0] PH_HOST   = 2'd1;
  localparam logic [1:0] PH_PORT   = 2'd2;
  localparam logic [1:0] PH_PATH   = 2'd3;

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic [7:0] http_char(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h68;
      2'd1:    r = 8'h74;
      2'd2:    r = 8'h74;
      default: r = 8'h70;
    endcase
    return r;
  endfunction

  logic [POS_W-1:0] position, position_next;
  logic [1:0]       phase, phase_next;
  logic [15:0]      prev_bytes, prev_bytes_next;
  logic             scheme_match, scheme_match_next;
  logic [POS_W-1:0] scheme_len, scheme_len_next;
  logic [POS_W-1:0] host_len, host_len_next;
  logic [31:0]      port_acc, port_acc_next;
  logic             port_ovfl, port_ovfl_next;
  logic [POS_W-1:0] path_start_r, path_start_next;
  logic             text_ended, text_ended_next;

  logic             out_valid;
  result_t          out_data;
  result_t          result_next;
  logic             out_free;

  logic [7:0]       c;
  logic             take;
  logic [3:0]       digit;
  logic [35:0]      port_prod;
  logic [POS_W-1:0] path_begin;

  assign out_free  = !out_valid || results.ready;
  // A terminating item needs room in the result register.
  assign item_take = item_valid && (!item.last_byte || out_free);

  assign c         = item.char_byte;
  assign take      = !text_ended && (c != 8'd0);
  assign digit     = c[3:0] - 4'd0;
  assign port_prod = {1'b0, port_acc, 3'b000} + {3'b000, port_acc, 1'b0} + 36'(digit);

  always_comb begin
    position_next     = position;
    phase_next        = phase;
    prev_bytes_next   = prev_bytes;
    scheme_match_next = scheme_match;
    scheme_len_next   = scheme_len;
    host_len_next     = host_len;
    port_acc_next     = port_acc;
    port_ovfl_next    = port_ovfl;
    path_start_next   = path_start_r;
    text_ended_next   = text_ended || (c == 8'd0);

    if (take) begin
      if (position < POS_W'(4) && lower_ascii(c) != http_char(position[1:0])) begin
        scheme_match_next = 1'b0;
      end
      case (phase)
        PH_SEARCH: begin
          if (c == 8'h2F && prev_bytes == 16'h3A2F && position >= POS_W'(2)) begin
            scheme_len_next = position - POS_W'(2);
            phase_next      = PH_HOST;
          end
        end
        PH_HOST: begin
          if (c == 8'h3A) begin
            phase_next = PH_PORT;
          end else if (c == 8'h2F) begin
            path_start_next = position;
            phase_next      = PH_PATH;
          end else begin
            host_len_next = host_len + POS_W'(1);
          end
        end
        PH_PORT: begin
          if (c >= 8'h30 && c <= 8'h39) begin
            if (port_prod[35:32] != 4'd0) begin
              port_ovfl_next = 1'b1;
            end
            port_acc_next = port_prod[31:0];
          end else begin
            path_start_next = position;
            phase_next      = PH_PATH;
          end
        end
        default: begin
        end
      endcase
      prev_bytes_next = {prev_bytes[7:0], c};
      position_next   = position + POS_W'(1);
      if (position_next >= MAX_POS) begin
        text_ended_next = 1'b1;
      end
    end
  end

  // Result built from the state as it stands after this item.
  assign path_begin = (phase_next == PH_PATH) ? path_start_next : position_next;

  always_comb begin
    result_next = '0;
    if (position_next == '0) begin
      result_next.status = ST_EMPTY;
    end else if (phase_next == PH_SEARCH) begin
      result_next.status = ST_NO_SEP;
    end else if (host_len_next == '0) begin
      result_next.status = ST_NO_HOST;
    end else if (port_ovfl_next) begin
      result_next.status = ST_PORT_OVFL;
    end else begin
      result_next.status        = ST_OK;
      result_next.scheme_id     = !(scheme_match_next && scheme_len_next == POS_W'(4));
      result_next.scheme_length = FIELD_W'(scheme_len_next);
      result_next.host_start    = FIELD_W'(scheme_len_next) + FIELD_W'(3);
      result_next.host_length   = FIELD_W'(host_len_next);
      result_next.port_number   = port_acc_next[15:0];
      result_next.path_start    = FIELD_W'(path_begin);
      result_next.path_length   = FIELD_W'(position_next) - FIELD_W'(path_begin);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (item_take && item.last_byte)) begin
      position     <= '0;
      phase        <= PH_SEARCH;
      prev_bytes   <= '0;
      scheme_match <= 1'b1;
      scheme_len   <= '0;
      host_len     <= '0;
      port_acc     <= '0;
      port_ovfl    <= 1'b0;
      path_start_r <= '0;
      text_ended   <= 1'b0;
    end else if (item_take) begin
      position     <= position_next;
      phase        <= phase_next;
      prev_bytes   <= prev_bytes_next;
      scheme_match <= scheme_match_next;
      scheme_len   <= scheme_len_next;
      host_len     <= host_len_next;
      port_acc     <= port_acc_next;
      port_ovfl    <= port_ovfl_next;
      path_start_r <= path_start_next;
      text_ended   <= text_ended_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= item_take && item.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && item_take && item.last_byte) begin
      out_data <= result_next;
    end
  end

  assign results.valid         = out_valid;
  assign results.status        = out_data.status;
  assign results.scheme_id     = out_data.scheme_id;
  assign results.scheme_length = out_data.scheme_length;
  assign results.host_start    = out_data.host_start;
  assign results.host_length   = out_data.host_length;
  assign results.port_number   = out_data.port_number;
  assign results.path_start    = out_data.path_start;
  assign results.path_length   = out_data.path_length;

endmodule

// ===== sv/url_component_splitter_top.sv =====
// Top level of the URL component splitter: input register plus parser.
// Depends on urlsplit_pkg, urlsplit_if, urlsplit_in_stage, urlsplit_parser.
//
// Usage: a URL arrives on the chars channel one byte per item, with
// last_byte set on its final item. A zero byte or MAX_URL_LEN characters
// end the text; later bytes are ignored until the item marked last.
// For every last item one result item leaves on the results channel with
// a status, the scheme identity (http or unknown) and the offsets and
// lengths of scheme, host and path, plus the port number modulo 65536.
// Whenever status is not ok, all other result fields are zero.
// An item is registered at the input and parsed from there; the result
// register loads when the last item is taken. Throughput: one item per
// cycle while the result register has room. Each item goes through one
// short update of the running state (compare, count, port times ten).
// When the receiver stalls, the result register holds its item; bytes that
// do not end a URL keep flowing, and a last item waits in the input
// register until the result register frees, which then backs up chars.
// Reset (rst, synchronous) empties both registers and returns the parse
// state to the start of a URL.
module url_component_splitter_top #(
  parameter int unsigned MAX_URL_LEN = urlsplit_pkg::URLSPLIT_MAX_LEN_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  urlsplit_in_if.sink    chars,
  urlsplit_out_if.source results
);
  import urlsplit_pkg::*;

  // Item held in the input register and its consume strobe.
  logic  item_valid;
  item_t item;
  logic  item_take;

  urlsplit_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  // The parser updates the running state and fills the result register.
  urlsplit_parser #(
    .MAX_URL_LEN (MAX_URL_LEN)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .results    (results)
  );

endmodule
